// ----- sv/mhns_pkg.sv -----
// Shared types and constants for the held note stack.
`timescale 1ns / 1ps

package mhns_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
	localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;

	typedef logic [7:0] status_t;
	typedef logic [6:0] note_t;
	typedef logic [6:0] velocity_t;
	typedef logic [3:0] query_t;
	typedef logic [4:0] count_t;

	typedef enum logic [1:0] {
		OP_QUERY,
		OP_PUSH,
		OP_PULL
	} op_t;

	typedef struct packed {
		op_t    op;
		note_t  note;
		query_t query;
	} cmd_t;

	typedef struct packed {
		note_t  queried_note;
		count_t held_count;
		logic   any_held;
		logic   dropped_oldest;
	} result_t;

endpackage

// ----- sv/mhns_if.sv -----
// Handshake channels for MIDI messages in and stack reports out.
`timescale 1ns / 1ps

interface mhns_msg_if;
	logic                valid;
	logic                ready;
	mhns_pkg::status_t   status_byte;
	mhns_pkg::note_t     note_number;
	mhns_pkg::velocity_t note_velocity;
	mhns_pkg::query_t    query_index;

	modport source (output valid, status_byte, note_number, note_velocity, query_index,
		input ready);
	modport sink (input valid, status_byte, note_number, note_velocity, query_index,
		output ready);
endinterface

interface mhns_res_if;
	logic             valid;
	logic             ready;
	mhns_pkg::note_t  queried_note;
	mhns_pkg::count_t held_count;
	logic             any_held;
	logic             dropped_oldest;

	modport source (output valid, queried_note, held_count, any_held, dropped_oldest,
		input ready);
	modport sink (input valid, queried_note, held_count, any_held, dropped_oldest,
		output ready);
endinterface

// ----- sv/mhns_stack_engine.sv -----
// Note stack storage with its shift, search and close sequencer.
`timescale 1ns / 1ps

module mhns_stack_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  mhns_pkg::cmd_t    cmd,
	output logic              cmd_ready,
	output logic              res_valid,
	output mhns_pkg::result_t res,
	input  logic              res_take
);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_SHIFT_UP = 5'b00010,
		ST_SEARCH   = 5'b00100,
		ST_CLOSE    = 5'b01000,
		ST_REPLY    = 5'b10000
	} state_t;

	state_t                         state_q;
	mhns_pkg::cmd_t                 cmd_q;
	logic [mhns_pkg::IDX_W-1:0]     idx_q;
	logic [mhns_pkg::CNT_W-1:0]     total_q;
	logic                           dropped_q;
	mhns_pkg::note_t                stack_q [mhns_pkg::STACK_DEPTH];

	logic [mhns_pkg::IDX_W-1:0]     rd_idx;
	mhns_pkg::note_t                rd_note;
	logic                           idx_last;
	logic                           full;
	logic                           wr_en;
	mhns_pkg::note_t                wr_data;

	assign full     = (total_q == mhns_pkg::CNT_W'(mhns_pkg::STACK_DEPTH));
	assign idx_last = ((mhns_pkg::CNT_W'(idx_q) + mhns_pkg::CNT_W'(1)) >= total_q);

	always_comb begin
		unique case (state_q)
			ST_SHIFT_UP: rd_idx = idx_q - mhns_pkg::IDX_W'(1);
			ST_CLOSE:    rd_idx = idx_q + mhns_pkg::IDX_W'(1);
			ST_REPLY:    rd_idx = mhns_pkg::IDX_W'(cmd_q.query);
			default:     rd_idx = idx_q;
		endcase
	end

	assign rd_note = stack_q[rd_idx];

	always_comb begin
		wr_en   = 1'b0;
		wr_data = rd_note;
		unique case (state_q)
			ST_SHIFT_UP: begin
				wr_en = 1'b1;
				if (idx_q == '0) begin
					wr_data = cmd_q.note;
				end
			end
			ST_CLOSE: wr_en = !idx_last;
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_q[idx_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			total_q   <= '0;
			idx_q     <= '0;
			dropped_q <= 1'b0;
			cmd_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q     <= cmd;
						dropped_q <= 1'b0;
						idx_q     <= '0;
						unique case (cmd.op)
							mhns_pkg::OP_PUSH: begin
								dropped_q <= full;
								if (full) begin
									idx_q <= mhns_pkg::IDX_W'(mhns_pkg::STACK_DEPTH - 1);
								end else begin
									idx_q   <= mhns_pkg::IDX_W'(total_q);
									total_q <= total_q + mhns_pkg::CNT_W'(1);
								end
								state_q <= ST_SHIFT_UP;
							end
							mhns_pkg::OP_PULL: begin
								state_q <= (total_q == '0) ? ST_REPLY : ST_SEARCH;
							end
							default: state_q <= ST_REPLY;
						endcase
					end
				end
				ST_SHIFT_UP: begin
					if (idx_q == '0) begin
						state_q <= ST_REPLY;
					end else begin
						idx_q <= idx_q - mhns_pkg::IDX_W'(1);
					end
				end
				ST_SEARCH: begin
					if (rd_note == cmd_q.note) begin
						state_q <= ST_CLOSE;
					end else if (idx_last) begin
						state_q <= ST_REPLY;
					end else begin
						idx_q <= idx_q + mhns_pkg::IDX_W'(1);
					end
				end
				ST_CLOSE: begin
					if (idx_last) begin
						total_q <= total_q - mhns_pkg::CNT_W'(1);
						state_q <= ST_REPLY;
					end else begin
						idx_q <= idx_q + mhns_pkg::IDX_W'(1);
					end
				end
				ST_REPLY: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_REPLY);

	always_comb begin
		res.queried_note   = (32'(cmd_q.query) < 32'(total_q)) ? rd_note : '0;
		res.held_count     = mhns_pkg::count_t'(total_q);
		res.any_held       = (total_q != '0);
		res.dropped_oldest = dropped_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= mhns_pkg::STACK_DEPTH)
		else $error("held count above stack depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.dropped_oldest |-> full)
		else $error("drop reported without a full stack");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT_UP |=> state_q == ST_SHIFT_UP || state_q == ST_REPLY)
		else $error("shift left before reaching the top");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLOSE |=> $past(total_q) == total_q
			|| $past(total_q) == total_q + mhns_pkg::CNT_W'(1))
		else $error("closing a gap changed the count by more than one");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REPLY && res_take |=> state_q == ST_IDLE)
		else $error("report taken but sequencer not idle");

endmodule

// ----- sv/midi_held_note_stack.sv -----
// Top level of the held note stack: message decode and report register.
//
//   channel  dir  carries
//   msg      in   status_byte, note_number, note_velocity, query_index
//   res      out  queried_note, held_count, any_held, dropped_oldest
//
// The single read/write port of the stack, stepped one entry per cycle by
// the sequencer, sets how long a message takes from transfer to report. Note
// on shifts the new count of entries, note off searches then closes the gap.
// No new message is taken meanwhile.
// A report waits in the output register while the stack takes the next message.
// Reset empties the stack at once; the stored notes are not cleared.
`timescale 1ns / 1ps

module midi_held_note_stack (
	input  logic       clk,
	input  logic       arst_n,
	mhns_msg_if.sink   msg,
	mhns_res_if.source res
);

	mhns_pkg::cmd_t    cmd;
	logic              cmd_ready;
	logic              eng_res_valid;
	mhns_pkg::result_t eng_res;
	logic              res_take;
	logic              res_valid_q;
	mhns_pkg::result_t res_q;

	always_comb begin
		cmd.note  = msg.note_number;
		cmd.query = msg.query_index;
		priority if (msg.status_byte == mhns_pkg::STATUS_NOTE_ON && msg.note_velocity != '0) begin
			cmd.op = mhns_pkg::OP_PUSH;
		end else if (msg.status_byte == mhns_pkg::STATUS_NOTE_ON
			|| msg.status_byte == mhns_pkg::STATUS_NOTE_OFF) begin
			cmd.op = mhns_pkg::OP_PULL;
		end else begin
			cmd.op = mhns_pkg::OP_QUERY;
		end
	end

	mhns_stack_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (msg.valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.res_valid (eng_res_valid),
		.res       (eng_res),
		.res_take  (res_take)
	);

	assign msg.ready = cmd_ready;
	assign res_take  = eng_res_valid && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_take) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			res_q <= eng_res;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.queried_note   = res_q.queried_note;
	assign res.held_count     = res_q.held_count;
	assign res.any_held       = res_q.any_held;
	assign res.dropped_oldest = res_q.dropped_oldest;

endmodule

// ----- test/midi_held_note_stack_test.sv -----
// Self-checking testbench for the held MIDI note stack, with random idling on both channels.
`timescale 1ns / 1ps

module midi_held_note_stack_test;
	import mhns_pkg::*;

	typedef struct packed {
		status_t   status;
		note_t     note;
		velocity_t vel;
		query_t    query;
	} midi_msg_t;

	logic clk;
	logic arst_n;

	mhns_msg_if msg_ch ();
	mhns_res_if res_ch ();

	midi_held_note_stack dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.res    (res_ch)
	);

	midi_msg_t pending_msgs[$];
	result_t   expected_reports[$];
	note_t     held_stack[STACK_DEPTH];
	int        held_depth;

	int msgs_queued;
	int msgs_loaded;
	int msgs_sent;
	int reports_seen;
	int mismatches;
	int note_ons;
	int note_offs;
	int ignored_msgs;
	int drops_seen;
	int deepest_fill;

	int send_gap;
	int stall_left;
	int stall_draw;
	int hold_left;
	bit hold_done;
	midi_msg_t next_msg;
	result_t   head_report;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	task automatic queue_msg(input status_t status, input note_t note, input velocity_t vel,
		input query_t query);
		midi_msg_t m;
		m.status = status;
		m.note   = note;
		m.vel    = vel;
		m.query  = query;
		pending_msgs.push_back(m);
		msgs_queued++;
	endtask

	// Apply one message to the tracked stack and queue the report it should produce.
	task automatic track_message(input midi_msg_t m);
		result_t want;
		int      pos;
		int      hit;
		want = '0;
		if (m.status == STATUS_NOTE_OFF || (m.status == STATUS_NOTE_ON && m.vel == 0)) begin
			note_offs++;
			hit = -1;
			for (pos = 0; pos < held_depth; pos++)
				if (hit < 0 && held_stack[pos] == m.note)
					hit = pos;
			if (hit >= 0) begin
				for (pos = hit; pos < held_depth - 1; pos++)
					held_stack[pos] = held_stack[pos + 1];
				held_depth--;
			end
		end else if (m.status == STATUS_NOTE_ON) begin
			note_ons++;
			if (held_depth == STACK_DEPTH) begin
				want.dropped_oldest = 1'b1;
				held_depth--;
			end
			for (pos = held_depth; pos > 0; pos--)
				held_stack[pos] = held_stack[pos - 1];
			held_stack[0] = m.note;
			held_depth++;
		end else begin
			ignored_msgs++;
		end
		if (m.query < held_depth)
			want.queried_note = held_stack[m.query];
		want.held_count = count_t'(held_depth);
		want.any_held   = (held_depth != 0);
		expected_reports.push_back(want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_ch.valid         <= 1'b0;
			msg_ch.status_byte   <= '0;
			msg_ch.note_number   <= '0;
			msg_ch.note_velocity <= '0;
			msg_ch.query_index   <= '0;
			send_gap             <= 0;
		end else begin
			if (msg_ch.valid && msg_ch.ready) begin
				track_message({msg_ch.status_byte, msg_ch.note_number, msg_ch.note_velocity,
					msg_ch.query_index});
				msgs_sent++;
			end
			if (!msg_ch.valid || msg_ch.ready) begin
				if (send_gap != 0) begin
					send_gap     <= send_gap - 1;
					msg_ch.valid <= 1'b0;
				end else if (pending_msgs.size() != 0) begin
					next_msg = pending_msgs.pop_front();
					msg_ch.status_byte   <= next_msg.status;
					msg_ch.note_number   <= next_msg.note;
					msg_ch.note_velocity <= next_msg.vel;
					msg_ch.query_index   <= next_msg.query;
					msg_ch.valid         <= 1'b1;
					send_gap <= ((msgs_loaded / 64) % 4 == 3) ? 0 : idle_length();
					msgs_loaded++;
				end else begin
					msg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off on the report side so the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && reports_seen >= 400) begin
			hold_left <= 300;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			res_ch.ready <= 1'b0;
		end else if (res_ch.valid && res_ch.ready) begin
			stall_draw = ((reports_seen / 80) % 4 == 1) ? 0 : idle_length();
			res_ch.ready <= (stall_draw == 0);
			stall_left   <= (stall_draw == 0) ? 0 : stall_draw - 1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			reports_seen++;
			if (res_ch.held_count > deepest_fill)
				deepest_fill = res_ch.held_count;
			if (res_ch.dropped_oldest)
				drops_seen++;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report %0d arrived with nothing outstanding", reports_seen);
			end else begin
				head_report = expected_reports.pop_front();
				if (res_ch.queried_note != head_report.queried_note ||
					res_ch.held_count != head_report.held_count ||
					res_ch.any_held != head_report.any_held ||
					res_ch.dropped_oldest != head_report.dropped_oldest) begin
					mismatches++;
					if (mismatches <= 10)
						$display("report %0d: expected note %0d count %0d any %0b drop %0b, %s",
							reports_seen, head_report.queried_note, head_report.held_count,
							head_report.any_held, head_report.dropped_oldest,
							$sformatf("got note %0d count %0d any %0b drop %0b",
							res_ch.queried_note, res_ch.held_count, res_ch.any_held,
							res_ch.dropped_oldest));
				end
			end
		end
	end

	initial begin
		#8ms;
		$display("midi_held_note_stack_test NOT OK");
		$finish;
	end

	initial begin
		note_t     opening_notes[17];
		note_t     pool[6];
		int        chosen;
		int        mode;
		int        seg_len;
		int        on_pct;
		int        r;
		int        i;
		status_t   status;
		note_t     note;
		velocity_t vel;

		msg_ch.valid         = 1'b0;
		msg_ch.status_byte   = '0;
		msg_ch.note_number   = '0;
		msg_ch.note_velocity = '0;
		msg_ch.query_index   = '0;
		res_ch.ready         = 1'b0;
		arst_n               = 1'b0;

		opening_notes = '{7'd0, 7'd127, 7'd60, 7'd60, 7'd64, 7'd67, 7'd72, 7'd48, 7'd36,
			7'd24, 7'd12, 7'd100, 7'd110, 7'd120, 7'd5, 7'd85, 7'd99};

		// Empty stack: query, unmatched note off, zero-velocity note on.
		queue_msg(8'hF8, 7'd127, 7'd127, 4'd0);
		queue_msg(STATUS_NOTE_OFF, 7'd60, 7'd64, 4'd15);
		queue_msg(STATUS_NOTE_ON, 7'd60, 7'd0, 4'd0);
		// Fill past the top so the oldest note falls out.
		for (i = 0; i < 17; i++)
			queue_msg(STATUS_NOTE_ON, opening_notes[i], (i % 2 == 0) ? 7'd1 : 7'd127,
				query_t'((i == 16) ? 15 : i));
		queue_msg(STATUS_NOTE_OFF, 7'd60, 7'd127, 4'd0);
		queue_msg(STATUS_NOTE_ON, 7'd127, 7'd0, 4'd15);
		queue_msg(STATUS_NOTE_OFF, 7'd0, 7'd1, 4'd3);
		queue_msg(8'h81, 7'd99, 7'd10, 4'd0);
		queue_msg(8'h91, 7'd99, 7'd10, 4'd14);
		queue_msg(8'hFF, 7'd0, 7'd0, 4'd15);
		queue_msg(8'h00, 7'd85, 7'd64, 4'd13);

		chosen = 0;
		while (chosen < 1950) begin
			mode    = $urandom_range(0, 2);
			seg_len = $urandom_range(20, 60);
			on_pct  = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
			for (i = 0; i < 6; i++)
				pool[i] = note_t'($urandom_range(0, 127));
			for (i = 0; i < seg_len; i++) begin
				r    = $urandom_range(0, 99);
				note = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 5)]
					: note_t'($urandom_range(0, 127));
				if (r < 10) begin
					status = ($urandom_range(0, 1) == 0) ? status_t'($urandom_range(0, 255))
						: status_t'($urandom_range(8'h81, 8'h9F));
					queue_msg(status, note_t'($urandom_range(0, 127)),
						velocity_t'($urandom_range(0, 127)), query_t'($urandom_range(0, 15)));
				end else begin
					if ($urandom_range(0, 99) < on_pct) begin
						status = STATUS_NOTE_ON;
						vel    = velocity_t'($urandom_range(1, 127));
					end else if ($urandom_range(0, 99) < 70) begin
						status = STATUS_NOTE_OFF;
						vel    = velocity_t'($urandom_range(0, 127));
					end else begin
						status = STATUS_NOTE_ON;
						vel    = '0;
					end
					queue_msg(status, note, vel, query_t'($urandom_range(0, 15)));
				end
				chosen++;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (msgs_sent != msgs_queued)
			@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d messages sent: %0d note on, %0d note off, %0d ignored",
			msgs_sent, note_ons, note_offs, ignored_msgs);
		$display("%0d reports checked, %0d oldest-note drops, deepest stack %0d, %0d mismatches",
			reports_seen, drops_seen, deepest_fill, mismatches);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("midi_held_note_stack_test OK");
		else
			$display("midi_held_note_stack_test NOT OK");
		$finish;
	end

endmodule
